// ----- hw/rtl/sft_pkg.sv -----
// Package: constants, codes, payload types and helpers for the SYN flood tracker.
`default_nettype none

package sft_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 256;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int USED_W      = $clog2(TABLE_DEPTH) + 1;

	// Field widths
	localparam int ADDR_W  = 32;
	localparam int COUNT_W = 32;
	localparam int THR_W   = 16;
	localparam int FLAGS_W = 6;

	// Reset value of the flood threshold
	localparam logic [THR_W-1:0] THR_RESET = 16'd20;

	// Item kinds
	localparam logic KIND_PACKET = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	// Flag patterns that are counted
	localparam logic [FLAGS_W-1:0] FLAGS_SYN_ONLY    = 6'h02;
	localparam logic [FLAGS_W-1:0] FLAGS_SYNACK_ONLY = 6'h12;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic               kind;
		logic [FLAGS_W-1:0] tcp_flags;
		logic [ADDR_W-1:0]  src_addr;
		logic [ADDR_W-1:0]  dst_addr;
		logic [7:0]         read_index;
	} item_t;

	typedef struct packed {
		logic               entry_valid;
		logic [7:0]         entry_slot;
		logic [ADDR_W-1:0]  host_addr;
		logic [COUNT_W-1:0] syn_total;
		logic [COUNT_W-1:0] synack_total;
		logic               flooded;
		logic               table_full;
		logic               counted;
	} result_t;

	// Saturating increment of a counter
	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/syn_flood_tracker_core.sv -----
// Top level: per-host SYN / SYN-ACK counter table with sequential address search.
//
//  channel  | signals                          | handshake
//  ---------+----------------------------------+-------------------------------------
//  item     | start, busy, item                | taken when start high and busy low
//  result   | result_valid, result             | one-cycle strobe, cannot be stalled
//  config   | cfg_valid, cfg_ready, cfg_data   | written when cfg_valid and cfg_ready
//
// A packet item scans the filled entries one per cycle through a single compare
// on the host table read port. busy stays high until the result strobe; an
// uncounted packet or out-of-range read is reported from idle without busy. Reset
// clears the fill count and sets the threshold to THR_RESET; the table itself is
// not cleared, since only filled entries are ever read. The result side never stalls.
`default_nettype none

module syn_flood_tracker_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output      logic                        busy,
	input  wire sft_pkg::item_t              item,
	output      logic                        result_valid,
	output      sft_pkg::result_t            result,
	input  wire logic                        cfg_valid,
	output      logic                        cfg_ready,
	input  wire logic [sft_pkg::THR_W-1:0]   cfg_data
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SCAN   = 6'b000010,
		ST_NEW    = 6'b000100,
		ST_FETCH  = 6'b001000,
		ST_MODIFY = 6'b010000,
		ST_REPORT = 6'b100000
	} state_t;

	state_t                          state_q;
	logic [sft_pkg::THR_W-1:0]       thr_q;
	logic [sft_pkg::USED_W-1:0]      used_q;
	logic [sft_pkg::USED_W-1:0]      scan_q;
	logic                            cmp_vld_q;
	logic [sft_pkg::SLOT_W-1:0]      cmp_slot_q;
	logic [sft_pkg::SLOT_W-1:0]      slot_q;
	logic [sft_pkg::ADDR_W-1:0]      addr_q;
	logic                            is_syn_q;
	logic                            count_q;
	logic [sft_pkg::ADDR_W-1:0]      host_q;
	logic [sft_pkg::COUNT_W-1:0]     syn_q;
	logic [sft_pkg::COUNT_W-1:0]     ack_q;
	logic                            res_vld_q;
	sft_pkg::result_t                res_q;

	// Table memories and their registered read data
	logic [sft_pkg::ADDR_W-1:0]      host_mem [sft_pkg::TABLE_DEPTH];
	logic [sft_pkg::COUNT_W-1:0]     syn_mem  [sft_pkg::TABLE_DEPTH];
	logic [sft_pkg::COUNT_W-1:0]     ack_mem  [sft_pkg::TABLE_DEPTH];
	logic [sft_pkg::ADDR_W-1:0]      host_rd_q;
	logic [sft_pkg::COUNT_W-1:0]     syn_rd_q;
	logic [sft_pkg::COUNT_W-1:0]     ack_rd_q;

	logic [sft_pkg::SLOT_W-1:0]      mem_addr;
	logic                            host_we;
	logic                            syn_we;
	logic                            ack_we;
	logic [sft_pkg::COUNT_W-1:0]     syn_wdata;
	logic [sft_pkg::COUNT_W-1:0]     ack_wdata;

	logic                            accept;
	logic                            pkt_syn;
	logic                            pkt_synack;
	logic                            hit;
	logic                            table_has_room;
	logic [sft_pkg::COUNT_W:0]       diff;
	logic                            flood;

	assign busy         = (state_q != ST_IDLE);
	assign accept       = start && !busy;
	assign cfg_ready    = 1'b1;
	assign result_valid = res_vld_q;
	assign result       = res_q;

	assign pkt_syn        = (item.tcp_flags == sft_pkg::FLAGS_SYN_ONLY);
	assign pkt_synack     = (item.tcp_flags == sft_pkg::FLAGS_SYNACK_ONLY);
	assign hit            = cmp_vld_q && (host_rd_q == addr_q);
	assign table_has_room = (used_q < sft_pkg::USED_W'(sft_pkg::TABLE_DEPTH));

	// Flood test on the registered counters
	assign diff  = {1'b0, syn_q} - {1'b0, ack_q};
	assign flood = !diff[sft_pkg::COUNT_W] &&
		(diff[sft_pkg::COUNT_W-1:0] > sft_pkg::COUNT_W'(thr_q));

	// Select the table address and write enables for the current step
	always_comb begin
		mem_addr  = slot_q;
		host_we   = 1'b0;
		syn_we    = 1'b0;
		ack_we    = 1'b0;
		syn_wdata = sft_pkg::sat_inc(syn_rd_q);
		ack_wdata = sft_pkg::sat_inc(ack_rd_q);
		unique case (state_q)
			ST_SCAN: begin
				mem_addr = scan_q[sft_pkg::SLOT_W-1:0];
			end
			ST_NEW: begin
				host_we   = 1'b1;
				syn_we    = 1'b1;
				ack_we    = 1'b1;
				syn_wdata = sft_pkg::COUNT_W'(is_syn_q);
				ack_wdata = sft_pkg::COUNT_W'(!is_syn_q);
			end
			ST_MODIFY: begin
				syn_we = count_q && is_syn_q;
				ack_we = count_q && !is_syn_q;
			end
			default: begin
			end
		endcase
	end

	// Write and read the table memories
	always_ff @(posedge clk) begin
		if (host_we) begin
			host_mem[slot_q] <= addr_q;
		end
		if (syn_we) begin
			syn_mem[slot_q] <= syn_wdata;
		end
		if (ack_we) begin
			ack_mem[slot_q] <= ack_wdata;
		end
		host_rd_q <= host_mem[mem_addr];
		syn_rd_q  <= syn_mem[mem_addr];
		ack_rd_q  <= ack_mem[mem_addr];
	end

	// Hold the flood threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= sft_pkg::THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// Sequence one item: scan, allocate or update, then report; a read skips the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			used_q    <= '0;
			scan_q    <= '0;
			cmp_vld_q <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			res_vld_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						scan_q    <= '0;
						cmp_vld_q <= 1'b0;
						if (item.kind == sft_pkg::KIND_READ) begin
							if (sft_pkg::USED_W'(item.read_index) < used_q) begin
								slot_q  <= sft_pkg::SLOT_W'(item.read_index);
								count_q <= 1'b0;
								state_q <= ST_FETCH;
							end else begin
								res_q.entry_valid  <= 1'b0;
								res_q.entry_slot   <= item.read_index;
								res_q.host_addr    <= '0;
								res_q.syn_total    <= '0;
								res_q.synack_total <= '0;
								res_q.flooded      <= 1'b0;
								res_q.table_full   <= 1'b0;
								res_q.counted      <= 1'b0;
								res_vld_q          <= 1'b1;
							end
						end else if (pkt_syn || pkt_synack) begin
							is_syn_q <= pkt_syn;
							addr_q   <= pkt_syn ? item.dst_addr : item.src_addr;
							count_q  <= 1'b1;
							state_q  <= ST_SCAN;
						end else begin
							res_q     <= '0;
							res_vld_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (hit) begin
						slot_q  <= cmp_slot_q;
						state_q <= ST_FETCH;
					end else if (scan_q < used_q) begin
						cmp_slot_q <= scan_q[sft_pkg::SLOT_W-1:0];
						cmp_vld_q  <= 1'b1;
						scan_q     <= scan_q + sft_pkg::USED_W'(1);
					end else if (cmp_vld_q) begin
						// drain the last compare
						cmp_vld_q <= 1'b0;
					end else if (table_has_room) begin
						slot_q  <= used_q[sft_pkg::SLOT_W-1:0];
						used_q  <= used_q + sft_pkg::USED_W'(1);
						state_q <= ST_NEW;
					end else begin
						res_q.entry_valid  <= 1'b0;
						res_q.entry_slot   <= '0;
						res_q.host_addr    <= addr_q;
						res_q.syn_total    <= '0;
						res_q.synack_total <= '0;
						res_q.flooded      <= 1'b0;
						res_q.table_full   <= 1'b1;
						res_q.counted      <= 1'b0;
						res_vld_q          <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				ST_NEW: begin
					host_q  <= addr_q;
					syn_q   <= sft_pkg::COUNT_W'(is_syn_q);
					ack_q   <= sft_pkg::COUNT_W'(!is_syn_q);
					state_q <= ST_REPORT;
				end
				ST_FETCH: begin
					state_q <= ST_MODIFY;
				end
				ST_MODIFY: begin
					host_q  <= host_rd_q;
					syn_q   <= syn_we ? syn_wdata : syn_rd_q;
					ack_q   <= ack_we ? ack_wdata : ack_rd_q;
					state_q <= ST_REPORT;
				end
				ST_REPORT: begin
					res_q.entry_valid  <= 1'b1;
					res_q.entry_slot   <= 8'(slot_q);
					res_q.host_addr    <= host_q;
					res_q.syn_total    <= syn_q;
					res_q.synack_total <= ack_q;
					res_q.flooded      <= flood;
					res_q.table_full   <= 1'b0;
					res_q.counted      <= count_q;
					res_vld_q          <= 1'b1;
					state_q            <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
